// ===== rtl/core/dpm_pkg.sv =====
package dpm_pkg;

   // Sizing
   localparam int NUM_TERMS    = 32;
   localparam int COEF_BITS    = 16;
   localparam int IN_COEF_BITS = 16;
   localparam int IN_EXP_BITS  = 5;
   localparam int ACC_BITS     = 40;
   localparam int OUT_EXP_BITS = 6;

   // Only exponents that the 5-bit field can reach are ever stored
   localparam int EXP_LIMIT    = (NUM_TERMS < 32) ? NUM_TERMS : 32;
   localparam int IDX_BITS     = $clog2(EXP_LIMIT);
   localparam int BUCKET_DEPTH = 2 * EXP_LIMIT - 1;
   localparam int BKT_BITS     = $clog2(BUCKET_DEPTH);
   localparam int PROD_BITS    = 2 * COEF_BITS;
   localparam int SUM_BITS     = ((COEF_BITS > IN_COEF_BITS) ? COEF_BITS : IN_COEF_BITS) + 1;

   localparam logic signed [SUM_BITS-1:0] SUM_MAX =
      SUM_BITS'((64'd1 << (COEF_BITS - 1)) - 64'd1);
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = ~SUM_MAX;

   typedef logic signed [COEF_BITS-1:0]    coef_type;
   typedef logic signed [IN_COEF_BITS-1:0] term_type;
   typedef logic signed [ACC_BITS-1:0]     acc_type;
   typedef logic signed [PROD_BITS-1:0]    prod_type;
   typedef logic [IDX_BITS-1:0]            idx_type;
   typedef logic [BKT_BITS-1:0]            bkt_addr_type;

   typedef enum logic [1:0] {
      OP_ADD_A = 2'd0,
      OP_ADD_B = 2'd1,
      OP_MUL   = 2'd2,
      OP_CLEAR = 2'd3
   } opcode_type;

   // Control of the coefficient store
   typedef struct packed {
      logic     clear;
      logic     rd_en;
      idx_type  rd_addr_a;
      idx_type  rd_addr_b;
      logic     wr_en_a;
      logic     wr_en_b;
      idx_type  wr_addr;
      coef_type wr_data;
   } coef_ctl_type;

   // One product to add into the bucket
   typedef struct packed {
      logic         valid;
      bkt_addr_type addr;
      acc_type      value;
   } bkt_acc_type;

   // Scan read of the bucket
   typedef struct packed {
      logic         rd_en;
      bkt_addr_type addr;
   } bkt_scan_type;

   // Stored coefficient plus term, clamped to the coefficient range
   function automatic coef_type sat_add(coef_type stored, term_type term);
      logic signed [SUM_BITS-1:0] s;
      logic signed [SUM_BITS-1:0] r;
      s = SUM_BITS'(stored) + SUM_BITS'(term);
      if (s > SUM_MAX) begin
         r = SUM_MAX;
      end else if (s < SUM_MIN) begin
         r = SUM_MIN;
      end else begin
         r = s;
      end
      return COEF_BITS'(r);
   endfunction

   // Product brought to the bucket width, wrapping where it is wider
   function automatic acc_type widen_prod(prod_type p);
      logic signed [63:0] w;
      w = 64'(p);
      return w[ACC_BITS-1:0];
   endfunction

endpackage

// ===== rtl/core/dpm_req_if.sv =====
interface dpm_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [1:0]                               opcode;
   logic signed [dpm_pkg::IN_COEF_BITS-1:0]  term_coef;
   logic [dpm_pkg::IN_EXP_BITS-1:0]          term_exponent;

   modport source (output valid, opcode, term_coef, term_exponent, input ready);
   modport sink (input valid, opcode, term_coef, term_exponent, output ready);
endinterface

// ===== rtl/core/dpm_rsp_if.sv =====
interface dpm_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [dpm_pkg::ACC_BITS-1:0]   product_coef;
   logic [dpm_pkg::OUT_EXP_BITS-1:0]      product_exponent;
   logic                                  is_empty;
   logic                                  is_last;

   modport source (output valid, product_coef, product_exponent, is_empty, is_last,
                   input ready);
   modport sink (input valid, product_coef, product_exponent, is_empty, is_last,
                 output ready);
endinterface

// ===== rtl/core/dpm_coef_mem.sv =====
// Coefficient store for A and B: one synchronous RAM each, registered read.
// Entries never written since reset or clear read as zero via valid bits.
module dpm_coef_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  dpm_pkg::coef_ctl_type ctl,
   output dpm_pkg::coef_type     rd_a,
   output dpm_pkg::coef_type     rd_b
);

   dpm_pkg::coef_type mem_a [dpm_pkg::EXP_LIMIT];
   dpm_pkg::coef_type mem_b [dpm_pkg::EXP_LIMIT];

   logic [dpm_pkg::EXP_LIMIT-1:0] valid_a_ff;
   logic [dpm_pkg::EXP_LIMIT-1:0] valid_b_ff;

   dpm_pkg::coef_type a_rd_ff;
   dpm_pkg::coef_type b_rd_ff;
   logic              a_hit_ff;
   logic              b_hit_ff;

   // Valid bits: cleared at once by reset or a clear item
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_a_ff <= '0;
         valid_b_ff <= '0;
      end else begin
         if (ctl.wr_en_a) begin
            valid_a_ff[ctl.wr_addr] <= 1'b1;
         end
         if (ctl.wr_en_b) begin
            valid_b_ff[ctl.wr_addr] <= 1'b1;
         end
      end
   end

   // RAM write and registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en_a) begin
         mem_a[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.wr_en_b) begin
         mem_b[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         a_rd_ff  <= mem_a[ctl.rd_addr_a];
         b_rd_ff  <= mem_b[ctl.rd_addr_b];
         a_hit_ff <= valid_a_ff[ctl.rd_addr_a];
         b_hit_ff <= valid_b_ff[ctl.rd_addr_b];
      end
   end

   assign rd_a = a_hit_ff ? a_rd_ff : '0;
   assign rd_b = b_hit_ff ? b_rd_ff : '0;

endmodule

// ===== rtl/core/dpm_bucket.sv =====
// Product bucket: one RAM with a registered read, read-modify-write for
// accumulation. A read that meets a write to the same entry on the same edge
// takes the written value by forwarding. Valid bits give the per-multiply clear.
module dpm_bucket (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  dpm_pkg::bkt_acc_type  acc,
   input  dpm_pkg::bkt_scan_type scan,
   output dpm_pkg::acc_type      rd_data,
   output logic                  idle
);

   dpm_pkg::acc_type mem [dpm_pkg::BUCKET_DEPTH];

   logic [dpm_pkg::BUCKET_DEPTH-1:0] valid_ff;

   logic                  rd_en;
   dpm_pkg::bkt_addr_type rd_addr;
   logic                  wr_en;
   dpm_pkg::bkt_addr_type wr_addr;
   dpm_pkg::acc_type      wr_data;

   dpm_pkg::acc_type      mem_rd_ff;
   logic                  hit_ff;
   logic                  fwd_ff;
   dpm_pkg::acc_type      fwd_data_ff;

   logic                  w_v_ff;
   dpm_pkg::bkt_addr_type w_addr_ff;
   dpm_pkg::acc_type      w_val_ff;

   // Shared read port: accumulation has priority, scans never overlap it
   assign rd_en   = acc.valid || scan.rd_en;
   assign rd_addr = acc.valid ? acc.addr : scan.addr;

   assign rd_data = fwd_ff ? fwd_data_ff : (hit_ff ? mem_rd_ff : '0);

   // Write stage: old value plus product, wraps at the bucket width
   assign wr_en   = w_v_ff;
   assign wr_addr = w_addr_ff;
   assign wr_data = rd_data + w_val_ff;
   assign idle    = !w_v_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_v_ff <= 1'b0;
      end else begin
         w_v_ff <= acc.valid;
      end
   end

   always_ff @(posedge clock) begin
      w_addr_ff <= acc.addr;
      w_val_ff  <= acc.value;
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_rd_ff   <= mem[rd_addr];
         hit_ff      <= valid_ff[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

endmodule

// ===== rtl/core/dense_polynomial_multiply_top.sv =====
// Dense polynomial multiplier. A and B hold one signed coefficient per
// exponent in two small RAMs; add-term items read, add with saturation and
// write back. A multiply item runs a single multiply-accumulate unit over
// every pair (i, j) of stored exponents, one pair per cycle, into a 63-entry
// product bucket RAM, then scans the bucket from the highest exponent down,
// reading and then checking each entry, and emits the nonzero terms with the
// last one marked (or a single term flagged empty). A stalled result port
// lengthens the scan. One item is worked on at a time, and the finished
// result register lets the next item be taken while the last term waits.
module dense_polynomial_multiply_top (
   input logic       clock,
   input logic       reset,
   dpm_req_if.sink   req_ch,
   dpm_rsp_if.source rsp_ch
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_MUL,
      S_FLUSH,
      S_SCAN,
      S_CHECK,
      S_FINAL
   } state_type;

   localparam dpm_pkg::idx_type      IDX_LAST = dpm_pkg::IDX_BITS'(dpm_pkg::EXP_LIMIT - 1);
   localparam dpm_pkg::bkt_addr_type K_LAST   =
      dpm_pkg::BKT_BITS'(dpm_pkg::BUCKET_DEPTH - 1);

   state_type state_ff, state_in;

   logic                  load_b_ff, load_b_in;
   logic                  load_go_ff, load_go_in;
   dpm_pkg::term_type     load_coef_ff, load_coef_in;
   dpm_pkg::idx_type      load_addr_ff, load_addr_in;
   dpm_pkg::idx_type      i_ff, i_in;
   dpm_pkg::idx_type      j_ff, j_in;
   dpm_pkg::bkt_addr_type scan_k_ff, scan_k_in;
   logic                  pend_v_ff, pend_v_in;
   dpm_pkg::acc_type      pend_coef_ff, pend_coef_in;
   dpm_pkg::bkt_addr_type pend_k_ff, pend_k_in;

   logic                              rsp_v_ff, rsp_v_in;
   dpm_pkg::acc_type                  out_coef_ff, out_coef_in;
   logic [dpm_pkg::OUT_EXP_BITS-1:0]  out_exp_ff, out_exp_in;
   logic                              out_empty_ff, out_empty_in;
   logic                              out_last_ff, out_last_in;

   // Multiply pipeline
   logic                  s1_v_ff;
   dpm_pkg::bkt_addr_type s1_k_ff;
   logic                  p_v_ff;
   dpm_pkg::bkt_addr_type p_k_ff;
   dpm_pkg::acc_type      p_val_ff;
   dpm_pkg::prod_type     prod;

   dpm_pkg::coef_ctl_type coef_ctl;
   dpm_pkg::coef_type     coef_rd_a;
   dpm_pkg::coef_type     coef_rd_b;
   dpm_pkg::coef_type     load_old;

   logic                  bkt_clear;
   dpm_pkg::bkt_acc_type  bkt_acc;
   dpm_pkg::bkt_scan_type bkt_scan;
   dpm_pkg::acc_type      bkt_rd;
   logic                  bkt_idle;

   logic accept;
   logic rsp_free;
   logic nz;

   dpm_coef_mem u_coef (
      .clock (clock),
      .reset (reset),
      .ctl   (coef_ctl),
      .rd_a  (coef_rd_a),
      .rd_b  (coef_rd_b)
   );

   dpm_bucket u_bucket (
      .clock   (clock),
      .reset   (reset),
      .clear   (bkt_clear),
      .acc     (bkt_acc),
      .scan    (bkt_scan),
      .rd_data (bkt_rd),
      .idle    (bkt_idle)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_v_ff || rsp_ch.ready;
   assign nz           = (bkt_rd != '0);

   assign rsp_ch.valid            = rsp_v_ff;
   assign rsp_ch.product_coef     = out_coef_ff;
   assign rsp_ch.product_exponent = out_exp_ff;
   assign rsp_ch.is_empty         = out_empty_ff;
   assign rsp_ch.is_last          = out_last_ff;

   assign load_old = load_b_ff ? coef_rd_b : coef_rd_a;
   assign prod     = dpm_pkg::PROD_BITS'(coef_rd_a) * dpm_pkg::PROD_BITS'(coef_rd_b);

   assign bkt_acc.valid = p_v_ff;
   assign bkt_acc.addr  = p_k_ff;
   assign bkt_acc.value = p_val_ff;

   // Sequencer: next state, memory controls and result register
   always_comb begin
      state_in     = state_ff;
      load_b_in    = load_b_ff;
      load_go_in   = load_go_ff;
      load_coef_in = load_coef_ff;
      load_addr_in = load_addr_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      scan_k_in    = scan_k_ff;
      pend_v_in    = pend_v_ff;
      pend_coef_in = pend_coef_ff;
      pend_k_in    = pend_k_ff;
      rsp_v_in     = rsp_v_ff && !rsp_ch.ready;
      out_coef_in  = out_coef_ff;
      out_exp_in   = out_exp_ff;
      out_empty_in = out_empty_ff;
      out_last_in  = out_last_ff;

      coef_ctl         = '0;
      coef_ctl.wr_addr = load_addr_ff;
      coef_ctl.wr_data = dpm_pkg::sat_add(load_old, load_coef_ff);
      bkt_clear        = 1'b0;
      bkt_scan         = '0;
      bkt_scan.addr    = scan_k_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_ch.opcode)
                  dpm_pkg::OP_ADD_A, dpm_pkg::OP_ADD_B: begin
                     coef_ctl.rd_en     = 1'b1;
                     coef_ctl.rd_addr_a = req_ch.term_exponent[dpm_pkg::IDX_BITS-1:0];
                     coef_ctl.rd_addr_b = req_ch.term_exponent[dpm_pkg::IDX_BITS-1:0];
                     load_b_in    = (req_ch.opcode == dpm_pkg::OP_ADD_B);
                     load_coef_in = req_ch.term_coef;
                     load_addr_in = req_ch.term_exponent[dpm_pkg::IDX_BITS-1:0];
                     // zero terms and exponents beyond storage change nothing
                     load_go_in   = (req_ch.term_coef != '0) &&
                                    ({1'b0, req_ch.term_exponent} <
                                     (dpm_pkg::IN_EXP_BITS + 1)'(dpm_pkg::EXP_LIMIT));
                     state_in     = S_LOAD;
                  end
                  dpm_pkg::OP_MUL: begin
                     bkt_clear = 1'b1;
                     i_in      = '0;
                     j_in      = '0;
                     scan_k_in = K_LAST;
                     pend_v_in = 1'b0;
                     state_in  = S_MUL;
                  end
                  default: begin
                     coef_ctl.clear = 1'b1;
                  end
               endcase
            end
         end
         S_LOAD: begin
            coef_ctl.wr_en_a = load_go_ff && !load_b_ff;
            coef_ctl.wr_en_b = load_go_ff && load_b_ff;
            state_in         = S_IDLE;
         end
         S_MUL: begin
            // one (i, j) pair read per cycle
            coef_ctl.rd_en     = 1'b1;
            coef_ctl.rd_addr_a = i_ff;
            coef_ctl.rd_addr_b = j_ff;
            if (j_ff == IDX_LAST) begin
               j_in = '0;
               if (i_ff == IDX_LAST) begin
                  state_in = S_FLUSH;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_FLUSH: begin
            if (!s1_v_ff && !p_v_ff && bkt_idle) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            bkt_scan.rd_en = 1'b1;
            state_in       = S_CHECK;
         end
         S_CHECK: begin
            // a held term goes out only once the next nonzero one is known
            if (!(nz && pend_v_ff && !rsp_free)) begin
               if (nz) begin
                  if (pend_v_ff) begin
                     rsp_v_in     = 1'b1;
                     out_coef_in  = pend_coef_ff;
                     out_exp_in   = dpm_pkg::OUT_EXP_BITS'(pend_k_ff);
                     out_empty_in = 1'b0;
                     out_last_in  = 1'b0;
                  end
                  pend_v_in    = 1'b1;
                  pend_coef_in = bkt_rd;
                  pend_k_in    = scan_k_ff;
               end
               if (scan_k_ff == '0) begin
                  state_in = S_FINAL;
               end else begin
                  scan_k_in = scan_k_ff - 1'b1;
                  state_in  = S_SCAN;
               end
            end
         end
         S_FINAL: begin
            if (rsp_free) begin
               rsp_v_in    = 1'b1;
               out_last_in = 1'b1;
               if (pend_v_ff) begin
                  out_coef_in  = pend_coef_ff;
                  out_exp_in   = dpm_pkg::OUT_EXP_BITS'(pend_k_ff);
                  out_empty_in = 1'b0;
               end else begin
                  out_coef_in  = '0;
                  out_exp_in   = '0;
                  out_empty_in = 1'b1;
               end
               pend_v_in = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pend_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pend_v_ff <= pend_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
      load_b_ff    <= load_b_in;
      load_go_ff   <= load_go_in;
      load_coef_ff <= load_coef_in;
      load_addr_ff <= load_addr_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      scan_k_ff    <= scan_k_in;
      pend_coef_ff <= pend_coef_in;
      pend_k_ff    <= pend_k_in;
      out_coef_ff  <= out_coef_in;
      out_exp_ff   <= out_exp_in;
      out_empty_ff <= out_empty_in;
      out_last_ff  <= out_last_in;
   end

   // Multiply pipeline: read, multiply, then into the bucket
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         p_v_ff  <= 1'b0;
      end else begin
         s1_v_ff <= (state_ff == S_MUL);
         p_v_ff  <= s1_v_ff;
      end
      s1_k_ff  <= dpm_pkg::BKT_BITS'(i_ff) + dpm_pkg::BKT_BITS'(j_ff);
      p_k_ff   <= s1_k_ff;
      p_val_ff <= dpm_pkg::widen_prod(prod);
   end

endmodule

// ===== tb/dense_polynomial_multiply_top_tb.sv =====
`timescale 1ns / 1ps

module dense_polynomial_multiply_top_tb;
   import dpm_pkg::*;

   localparam longint COEF_TOP    = (longint'(1) <<< (COEF_BITS - 1)) - 1;
   localparam longint COEF_BOTTOM = -COEF_TOP - 1;

   typedef logic [IN_EXP_BITS-1:0] term_exp_type;

   // One term of a product run as it leaves the block
   typedef struct packed {
      acc_type                 coef;
      logic [OUT_EXP_BITS-1:0] exponent;
      logic                    is_empty;
      logic                    is_last;
   } product_term_type;

   // Tracks both polynomials and holds the product terms still owed
   class product_scoreboard;
      coef_type         poly_a[EXP_LIMIT];
      coef_type         poly_b[EXP_LIMIT];
      product_term_type owed[$];
      int               failures;

      function new();
         foreach (poly_a[i]) begin
            poly_a[i] = '0;
            poly_b[i] = '0;
         end
         failures = 0;
      endfunction

      // Held coefficient plus new term, clamped to the coefficient range
      function coef_type clamp_sum(coef_type held, term_type coef);
         longint s;
         s = longint'(held) + longint'(coef);
         if (s > COEF_TOP) s = COEF_TOP;
         if (s < COEF_BOTTOM) s = COEF_BOTTOM;
         return coef_type'(s);
      endfunction

      // Work out the product run of A times B and queue its terms
      function void queue_product();
         acc_type          bucket[BUCKET_DEPTH];
         int               lowest;
         product_term_type t;
         foreach (bucket[k]) bucket[k] = '0;
         for (int i = 0; i < EXP_LIMIT; i++) begin
            if (poly_a[i] == 0) continue;
            for (int j = 0; j < EXP_LIMIT; j++) begin
               if (poly_b[j] == 0) continue;
               bucket[i+j] = bucket[i+j] + acc_type'(longint'(poly_a[i]) * longint'(poly_b[j]));
            end
         end
         lowest = -1;
         for (int k = BUCKET_DEPTH - 1; k >= 0; k--) begin
            if (bucket[k] != 0) lowest = k;
         end
         if (lowest < 0) begin
            t = '{coef: '0, exponent: '0, is_empty: 1'b1, is_last: 1'b1};
            owed.push_back(t);
            return;
         end
         for (int k = BUCKET_DEPTH - 1; k >= lowest; k--) begin
            if (bucket[k] != 0) begin
               t.coef     = bucket[k];
               t.exponent = OUT_EXP_BITS'(k);
               t.is_empty = 1'b0;
               t.is_last  = (k == lowest);
               owed.push_back(t);
            end
         end
      endfunction

      // Called for every accepted input item
      function void note_item(opcode_type op, term_type coef, term_exp_type exponent);
         case (op)
            OP_ADD_A: begin
               if (coef != 0 && exponent < EXP_LIMIT)
                  poly_a[exponent] = clamp_sum(poly_a[exponent], coef);
            end
            OP_ADD_B: begin
               if (coef != 0 && exponent < EXP_LIMIT)
                  poly_b[exponent] = clamp_sum(poly_b[exponent], coef);
            end
            OP_MUL: begin
               queue_product();
            end
            OP_CLEAR: begin
               foreach (poly_a[i]) begin
                  poly_a[i] = '0;
                  poly_b[i] = '0;
               end
            end
            default: begin
            end
         endcase
      endfunction

      // Called for every accepted result item
      function void check_term(product_term_type seen);
         product_term_type want;
         if (owed.size() == 0) begin
            failures++;
            $display("%0t: unexpected result coef=%0d exp=%0d empty=%0b last=%0b", $time,
                     seen.coef, seen.exponent, seen.is_empty, seen.is_last);
            return;
         end
         want = owed.pop_front();
         if (seen !== want) begin
            failures++;
            $display("%0t: mismatch expected coef=%0d exp=%0d empty=%0b last=%0b", $time,
                     want.coef, want.exponent, want.is_empty, want.is_last);
            $display("%0t:          actual   coef=%0d exp=%0d empty=%0b last=%0b", $time,
                     seen.coef, seen.exponent, seen.is_empty, seen.is_last);
         end
      endfunction

      function int pending();
         return owed.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;
   int   sent_count;

   product_scoreboard products = new();
   product_term_type  seen_term;

   dpm_req_if req_ch ();
   dpm_rsp_if rsp_ch ();

   dense_polynomial_multiply_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Result side: random back-pressure, none during the calm stretch
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = !reset && (calm || $urandom_range(99) >= 35);
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen_term.coef     = rsp_ch.product_coef;
         seen_term.exponent = rsp_ch.product_exponent;
         seen_term.is_empty = rsp_ch.is_empty;
         seen_term.is_last  = rsp_ch.is_last;
         products.check_term(seen_term);
      end
   end

   // Drive one item, with random gaps ahead of it, and wait for acceptance
   task automatic send_item(opcode_type op, term_type coef, term_exp_type exponent);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 35) begin
         req_ch.valid         = 1'b0;
         req_ch.term_coef     = term_type'($urandom);
         req_ch.term_exponent = term_exp_type'($urandom);
         @(negedge clock);
      end
      req_ch.valid         = 1'b1;
      req_ch.opcode        = op;
      req_ch.term_coef     = coef;
      req_ch.term_exponent = exponent;
      do @(posedge clock); while (!req_ch.ready);
      products.note_item(op, coef, exponent);
      sent_count++;
   endtask

   // Hold off the sender until every owed term has come back
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (products.pending() != 0) @(posedge clock);
   endtask

   // Mix of extremes, small values for cancellation, zero and full-range values
   function automatic term_type pick_coef();
      case ($urandom_range(9))
         0:       return term_type'(COEF_TOP);
         1:       return term_type'(COEF_BOTTOM);
         2:       return '0;
         3, 4:    return term_type'(int'($urandom_range(20)) - 10);
         default: return term_type'($urandom);
      endcase
   endfunction

   function automatic term_type pick_nonzero_coef();
      term_type c;
      do c = pick_coef(); while (c == 0);
      return c;
   endfunction

   function automatic term_exp_type pick_exponent();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return term_exp_type'($urandom_range(3));
         default: return term_exp_type'($urandom);
      endcase
   endfunction

   function automatic opcode_type pick_load();
      return ($urandom_range(1) == 0) ? OP_ADD_A : OP_ADD_B;
   endfunction

   // Stimulus
   initial begin
      int random_start;
      int round;
      int loads;

      reset                = 1'b1;
      calm                 = 1'b0;
      sent_count           = 0;
      req_ch.valid         = 1'b0;
      req_ch.opcode        = OP_CLEAR;
      req_ch.term_coef     = '0;
      req_ch.term_exponent = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty product, saturation both ways, ignored zero term,
      // extreme exponents, coefficient cancellation, clear, bucket cancellation
      send_item(OP_MUL, 16'sd0, 5'd0);
      send_item(OP_ADD_A, 16'sd32767, 5'd0);
      send_item(OP_ADD_A, 16'sd32767, 5'd0);
      send_item(OP_ADD_B, -16'sd32768, 5'd31);
      send_item(OP_ADD_B, -16'sd1, 5'd31);
      send_item(OP_ADD_A, 16'sd0, 5'd7);
      send_item(OP_MUL, 16'sd0, 5'd0);
      send_item(OP_ADD_A, -16'sd32768, 5'd31);
      send_item(OP_ADD_B, 16'sd5, 5'd0);
      send_item(OP_MUL, 16'sd0, 5'd0);
      send_item(OP_ADD_A, 16'sd100, 5'd9);
      send_item(OP_ADD_A, -16'sd100, 5'd9);
      send_item(OP_ADD_A, -16'sd32768, 5'd0);
      send_item(OP_ADD_A, 16'sd1, 5'd0);
      send_item(OP_MUL, 16'sd0, 5'd0);
      send_item(OP_CLEAR, 16'sd0, 5'd0);
      send_item(OP_MUL, 16'sd0, 5'd0);
      send_item(OP_ADD_B, 16'sd1, 5'd3);
      send_item(OP_MUL, 16'sd0, 5'd0);
      send_item(OP_ADD_A, 16'sd1, 5'd0);
      send_item(OP_ADD_A, 16'sd1, 5'd1);
      send_item(OP_ADD_B, 16'sd1, 5'd0);
      send_item(OP_ADD_B, -16'sd1, 5'd1);
      send_item(OP_MUL, 16'sd0, 5'd0);
      send_item(OP_CLEAR, 16'sd0, 5'd0);
      drain_results();

      // Random: mostly load runs ending in a multiply, some noise
      random_start = sent_count;
      round        = 0;
      while (sent_count - random_start < 75) begin
         calm = (sent_count - random_start >= 25) && (sent_count - random_start < 50);
         if (round == 0 || $urandom_range(19) == 0) begin
            // Full-width run: every product exponent comes out nonzero but 31, where two products may cancel
            send_item(OP_CLEAR, pick_coef(), pick_exponent());
            send_item(OP_ADD_A, pick_nonzero_coef(), 5'd0);
            send_item(OP_ADD_A, pick_nonzero_coef(), 5'd31);
            for (int e = 0; e < EXP_LIMIT; e++)
               send_item(OP_ADD_B, term_type'($urandom_range(1000, 1)), term_exp_type'(e));
            send_item(OP_MUL, pick_coef(), pick_exponent());
         end else if ($urandom_range(99) < 10) begin
            send_item(opcode_type'($urandom_range(3)), term_type'($urandom),
                      term_exp_type'($urandom));
         end else begin
            if ($urandom_range(3) == 0)
               send_item(OP_CLEAR, pick_coef(), pick_exponent());
            loads = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
            for (int n = 0; n < loads; n++)
               send_item(pick_load(), pick_coef(), pick_exponent());
            send_item(OP_MUL, pick_coef(), pick_exponent());
         end
         round++;
      end
      calm = 1'b0;
      drain_results();

      // Let any stray term show before deciding
      repeat (1300) @(posedge clock);
      if (products.failures == 0) begin
         $display("dense_polynomial_multiply_top_tb passed");
      end else begin
         $display("dense_polynomial_multiply_top_tb failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("dense_polynomial_multiply_top_tb failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/dpm_pkg.sv
rtl/core/dpm_req_if.sv
rtl/core/dpm_rsp_if.sv
rtl/core/dpm_coef_mem.sv
rtl/core/dpm_bucket.sv
rtl/core/dense_polynomial_multiply_top.sv
tb/dense_polynomial_multiply_top_tb.sv
